FILE: rtl/btmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared sizes, types and codes of the binary trie maximum-xor block.
// ----------------------------------------------------------------------------
package btmx_pkg;

	localparam int KEY_BITS   = 31;
	localparam int MAX_NODES  = 4096;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int CNT_W      = $clog2(MAX_NODES + 1);
	localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int FULL_LIMIT = MAX_NODES - KEY_BITS;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [KEY_BITS-1:0] key;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0] one;
		logic [NODE_W-1:0] zero;
	} node_t;

endpackage

FILE: rtl/btmx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_front
// Accepts requests, classifies the operation and holds them in a two-entry
// queue for the walk engine.
// ----------------------------------------------------------------------------
module btmx_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [btmx_pkg::KEY_BITS-1:0] key,
	output logic                         q_valid,
	output btmx_pkg::item_t              q_item,
	input  logic                         q_pop
);

	btmx_pkg::item_t slot_q [2];
	btmx_pkg::item_t item_in;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign item_in.kind = btmx_pkg::op_kind_t'(op);
	assign item_in.key  = key;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/btmx_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_walk
// Walk engine: holds the node store, walks one trie level a cycle for inserts
// and queries, and registers the result towards the output channel.
// ----------------------------------------------------------------------------
module btmx_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  btmx_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [btmx_pkg::KEY_BITS-1:0] max_xor,
	output logic                          found,
	output logic                          full_res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESULT
	} state_t;

	state_t                         state_q;
	btmx_pkg::node_t                node_mem [btmx_pkg::MAX_NODES];
	btmx_pkg::node_t                rd_q;
	logic                           root_valid_q;
	logic [btmx_pkg::CNT_W-1:0]     nodes_used_q;
	btmx_pkg::op_kind_t             kind_q;
	logic [btmx_pkg::KEY_BITS-1:0]  key_q;
	logic [btmx_pkg::KEY_BITS-1:0]  acc_q;
	logic [btmx_pkg::LVL_W-1:0]     lvl_q;
	logic [btmx_pkg::NODE_W-1:0]    cur_q;
	logic                           fresh_q;
	logic                           found_q;
	logic                           full_q;
	logic                           out_valid_q;
	logic [btmx_pkg::KEY_BITS-1:0]  max_xor_q;
	logic                           found_out_q;
	logic                           full_out_q;

	btmx_pkg::node_t                entry;
	btmx_pkg::node_t                wr_data;
	logic                           key_bit;
	logic [btmx_pkg::NODE_W-1:0]    child_same;
	logic [btmx_pkg::NODE_W-1:0]    child_opp;
	logic [btmx_pkg::NODE_W-1:0]    new_idx;
	logic [btmx_pkg::NODE_W-1:0]    nxt;
	logic [btmx_pkg::NODE_W-1:0]    rd_addr;
	logic                           take_opp;
	logic                           alloc;
	logic                           wr_en;
	logic                           is_full;
	logic                           is_empty;
	logic                           out_free;

	// node store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[cur_q] <= wr_data;
		end
		rd_q <= node_mem[rd_addr];
	end

	// walk step
	always_comb begin
		entry      = (cur_q == '0 && !root_valid_q) ? btmx_pkg::node_t'('0) : rd_q;
		key_bit    = key_q[lvl_q];
		child_same = key_bit ? entry.one : entry.zero;
		child_opp  = key_bit ? entry.zero : entry.one;
		new_idx    = nodes_used_q[btmx_pkg::NODE_W-1:0];
		take_opp   = (child_opp != '0);
		alloc      = fresh_q || (child_same == '0);
		if (kind_q == btmx_pkg::OP_QUERY) begin
			nxt = take_opp ? child_opp : child_same;
		end else begin
			nxt = alloc ? new_idx : child_same;
		end
		wr_data = fresh_q ? btmx_pkg::node_t'('0) : entry;
		if (key_bit) begin
			wr_data.one = new_idx;
		end else begin
			wr_data.zero = new_idx;
		end
		wr_en   = (state_q == ST_WALK) && (kind_q == btmx_pkg::OP_INSERT) && alloc;
		rd_addr = (state_q == ST_WALK) ? nxt : '0;
	end

	assign is_full  = nodes_used_q > btmx_pkg::CNT_W'(btmx_pkg::FULL_LIMIT);
	assign is_empty = nodes_used_q == btmx_pkg::CNT_W'(1);
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			root_valid_q <= 1'b0;
			nodes_used_q <= btmx_pkg::CNT_W'(1);
			kind_q       <= btmx_pkg::OP_INSERT;
			key_q        <= '0;
			acc_q        <= '0;
			lvl_q        <= '0;
			cur_q        <= '0;
			fresh_q      <= 1'b0;
			found_q      <= 1'b0;
			full_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			max_xor_q    <= '0;
			found_out_q  <= 1'b0;
			full_out_q   <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						kind_q  <= q_item.kind;
						key_q   <= q_item.key;
						acc_q   <= '0;
						lvl_q   <= btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
						cur_q   <= '0;
						fresh_q <= 1'b0;
						found_q <= 1'b0;
						full_q  <= 1'b0;
						if (q_item.kind == btmx_pkg::OP_INSERT) begin
							if (is_full) begin
								full_q  <= 1'b1;
								state_q <= ST_RESULT;
							end else begin
								state_q <= ST_WALK;
							end
						end else begin
							if (is_empty) begin
								state_q <= ST_RESULT;
							end else begin
								found_q <= 1'b1;
								state_q <= ST_WALK;
							end
						end
					end
				end
				ST_WALK: begin
					cur_q <= nxt;
					if (kind_q == btmx_pkg::OP_QUERY) begin
						if (take_opp) begin
							acc_q[lvl_q] <= 1'b1;
						end
					end else if (alloc) begin
						nodes_used_q <= nodes_used_q + btmx_pkg::CNT_W'(1);
						fresh_q      <= 1'b1;
						if (cur_q == '0) begin
							root_valid_q <= 1'b1;
						end
					end
					if (lvl_q == '0) begin
						state_q <= ST_RESULT;
					end else begin
						lvl_q <= lvl_q - btmx_pkg::LVL_W'(1);
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						max_xor_q   <= acc_q;
						found_out_q <= found_q;
						full_out_q  <= full_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign max_xor   = max_xor_q;
	assign found     = found_out_q;
	assign full_res  = full_out_q;

endmodule

FILE: rtl/binary_trie_max_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Binary trie of fixed depth with insert and maximum-xor query.
// ----------------------------------------------------------------------------
// usage
//   request channel: in_valid / in_stall with op (0 insert, 1 query) and key
//   result channel: out_valid / out_stall with max_xor, found and full_res;
//   exactly one result per request, in request order
//   a two-entry queue takes requests while the walk engine is busy
//   a walking request passes through the engine in order: the root fetch,
//   one step per key bit (one node store read each) and the load of the result
//   register; the engine takes the next request only once that one is done
//   a rejected insert (store nearly full) or a query on an empty trie
//   walks nothing
//   when the receiver stalls, the result is held and the engine waits with
//   the next result ready; the queue keeps taking requests until it is full
//   reset empties the trie at once; the node store needs no clearing pass
// ----------------------------------------------------------------------------
module binary_trie_max_xor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [btmx_pkg::KEY_BITS-1:0] key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [btmx_pkg::KEY_BITS-1:0] max_xor,
	output logic                          found,
	output logic                          full_res
);

	logic            q_valid;
	logic            q_pop;
	btmx_pkg::item_t q_item;

	btmx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.key      (key),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	btmx_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.max_xor   (max_xor),
		.found     (found),
		.full_res  (full_res)
	);

endmodule

FILE: rtl/btmx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_checker
// Port-level checks of the binary trie block, bound to the top level.
// ----------------------------------------------------------------------------
module btmx_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          op,
	input logic [btmx_pkg::KEY_BITS-1:0] key,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [btmx_pkg::KEY_BITS-1:0] max_xor,
	input logic                          found,
	input logic                          full_res
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its fields
	a_out_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(max_xor) && $stable(found) && $stable(full_res))
		else $error("result fields changed while stalled");

	// a stalled request stays offered with its fields
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(op) && $stable(key))
		else $error("request changed while stalled");

	// a query result never carries the insert flag
	a_found_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !full_res)
		else $error("found and full_res both set");

	// no stored key, no xor value
	a_no_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> max_xor == '0)
		else $error("max_xor set without a stored key");

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (.*);
